@@ hw/rtl/hus_pkg.sv @@
// ----------------------------------------------------------------------------
// hus_pkg: shared types for the https URL splitter
// Beat and verdict records passed between the splitter's stages.
// ----------------------------------------------------------------------------
package hus_pkg;

  localparam int unsigned MAX_URL_LEN_DEF = 2048;

  // fixed field widths of the verdict
  localparam int unsigned OFS_W  = 12;
  localparam int unsigned PLEN_W = 3;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       last_byte;
  } hus_beat_t;

  typedef struct packed {
    logic              valid_res;
    logic [OFS_W-1:0]  host_start;
    logic [OFS_W-1:0]  host_len;
    logic              ipv6_host;
    logic [OFS_W-1:0]  port_start;
    logic [PLEN_W-1:0] port_len;
    logic              port_is_default;
    logic [OFS_W-1:0]  path_start;
    logic [OFS_W-1:0]  path_len;
    logic              path_is_default;
  } hus_res_t;

endpackage

@@ hw/rtl/hus_in_reg.sv @@
// ----------------------------------------------------------------------------
// hus_in_reg: input beat register
// Holds one URL byte for the parser; refills in the cycle it is taken.
// ----------------------------------------------------------------------------
module hus_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_byte,
  input  logic              last_byte,
  input  logic              take,
  output logic              beat_valid,
  output hus_pkg::hus_beat_t beat
);
  import hus_pkg::*;

  logic accept;

  assign in_stall = beat_valid && !take;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (accept) begin
      beat_valid <= 1'b1;
    end else if (take) begin
      beat_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat.char_byte <= char_byte;
      beat.last_byte <= last_byte;
    end
  end

endmodule

@@ hw/rtl/hus_parser.sv @@
// ----------------------------------------------------------------------------
// hus_parser: per-byte URL parse state
// Phase tracking, offsets and port value; forms the verdict on the last byte.
// ----------------------------------------------------------------------------
module hus_parser #(
  parameter int unsigned MAX_URL_LEN = hus_pkg::MAX_URL_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               beat_valid,
  input  hus_pkg::hus_beat_t beat,
  input  logic               room,
  output logic               take,
  output logic               res_load,
  output hus_pkg::hus_res_t  res
);
  import hus_pkg::*;

  localparam int unsigned CW = $clog2(MAX_URL_LEN + 2);
  localparam int unsigned PW = (CW > OFS_W) ? CW : OFS_W;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUERY = 8'h3F;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [PLEN_W-1:0] MAX_DIGITS = PLEN_W'(5);
  localparam logic [19:0] MAX_PORT = 20'd65535;
  localparam logic [PW-1:0] MIN_LEN = PW'(9);

  typedef enum logic [2:0] {
    PH_PREFIX, PH_HOST_FIRST, PH_HOST_PLAIN, PH_HOST_BRACKET,
    PH_AFTER_BRACKET, PH_PORT, PH_PATH
  } phase_t;

  function automatic logic [7:0] scheme_byte(input logic [2:0] i);
    logic [7:0] b;
    unique case (i)
      3'd0:    b = 8'h68;  // h
      3'd1:    b = 8'h74;  // t
      3'd2:    b = 8'h74;  // t
      3'd3:    b = 8'h70;  // p
      3'd4:    b = 8'h73;  // s
      3'd5:    b = 8'h3A;  // :
      3'd6:    b = 8'h2F;  // /
      default: b = 8'h2F;  // /
    endcase
    return b;
  endfunction

  phase_t            phase, phase_next;
  logic [PW-1:0]     position, position_next;
  logic [PW-1:0]     host_begin, host_begin_next;
  logic [PW-1:0]     host_count, host_count_next;
  logic              bracketed, bracketed_next;
  logic [PW-1:0]     port_begin, port_begin_next;
  logic [PLEN_W-1:0] port_digits, port_digits_next;
  logic [16:0]       port_value, port_value_next;
  logic [PW-1:0]     path_begin, path_begin_next;
  logic              failed, failed_next;

  logic [7:0]  c;
  logic        delim;
  logic [19:0] pv_wide;
  logic [19:0] pv_prod;
  logic        ok;
  logic        has_port;
  logic        has_path;
  logic [PW-1:0] path_count;

  assign take     = beat_valid && (!beat.last_byte || room);
  assign res_load = take && beat.last_byte;

  assign c       = beat.char_byte;
  assign delim   = (c == CH_SLASH) || (c == CH_QUERY) || (c == CH_HASH);
  assign pv_wide = {3'b000, port_value};
  // value * 10 + digit as two shifted adds
  assign pv_prod = (pv_wide << 3) + (pv_wide << 1) + {16'd0, c[3:0]};

  always_comb begin
    phase_next       = phase;
    host_begin_next  = host_begin;
    host_count_next  = host_count;
    bracketed_next   = bracketed;
    port_begin_next  = port_begin;
    port_digits_next = port_digits;
    port_value_next  = port_value;
    path_begin_next  = path_begin;
    failed_next      = failed;
    position_next    = (position <= PW'(MAX_URL_LEN)) ? position + PW'(1) : position;

    if (position >= PW'(MAX_URL_LEN)) begin
      failed_next = 1'b1;
    end else if (!failed) begin
      unique case (phase)
        PH_PREFIX: begin
          if (c != scheme_byte(position[2:0])) begin
            failed_next = 1'b1;
          end else if (position >= PW'(7)) begin
            phase_next = PH_HOST_FIRST;
          end
        end
        PH_HOST_FIRST: begin
          if (c == CH_LBRK) begin
            bracketed_next  = 1'b1;
            host_begin_next = position + PW'(1);
            phase_next      = PH_HOST_BRACKET;
          end else if (c == CH_COLON || delim) begin
            failed_next = 1'b1;
          end else begin
            host_begin_next = position;
            host_count_next = PW'(1);
            phase_next      = PH_HOST_PLAIN;
          end
        end
        PH_HOST_PLAIN: begin
          if (c == CH_COLON) begin
            port_begin_next = position + PW'(1);
            phase_next      = PH_PORT;
          end else if (delim) begin
            path_begin_next = position;
            phase_next      = PH_PATH;
          end else begin
            host_count_next = host_count + PW'(1);
          end
        end
        PH_HOST_BRACKET: begin
          if (c == CH_RBRK) begin
            if (host_count == '0) failed_next = 1'b1;
            else phase_next = PH_AFTER_BRACKET;
          end else begin
            host_count_next = host_count + PW'(1);
          end
        end
        PH_AFTER_BRACKET: begin
          if (c == CH_COLON) begin
            port_begin_next = position + PW'(1);
            phase_next      = PH_PORT;
          end else begin
            path_begin_next = position;
            phase_next      = PH_PATH;
          end
        end
        PH_PORT: begin
          if (delim) begin
            if (port_digits == '0) begin
              failed_next = 1'b1;
            end else begin
              path_begin_next = position;
              phase_next      = PH_PATH;
            end
          end else if (c < CH_ZERO || c > CH_NINE || port_digits >= MAX_DIGITS) begin
            failed_next = 1'b1;
          end else begin
            port_value_next  = pv_prod[16:0];
            port_digits_next = port_digits + PLEN_W'(1);
            if (pv_prod > MAX_PORT) failed_next = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // verdict from the state as it stands after this byte
  always_comb begin
    ok = !failed_next && (position_next >= MIN_LEN);
    if (phase_next == PH_PREFIX || phase_next == PH_HOST_FIRST ||
        phase_next == PH_HOST_BRACKET) begin
      ok = 1'b0;
    end
    if (phase_next == PH_PORT && port_digits_next == '0) ok = 1'b0;
    has_port   = port_digits_next != '0;
    has_path   = phase_next == PH_PATH;
    path_count = position_next - path_begin_next;

    res = '0;
    if (ok) begin
      res.valid_res       = 1'b1;
      res.host_start      = host_begin_next[OFS_W-1:0];
      res.host_len        = host_count_next[OFS_W-1:0];
      res.ipv6_host       = bracketed_next;
      res.port_start      = has_port ? port_begin_next[OFS_W-1:0] : '0;
      res.port_len        = has_port ? port_digits_next : '0;
      res.port_is_default = !has_port;
      res.path_start      = has_path ? path_begin_next[OFS_W-1:0] : '0;
      res.path_len        = has_path ? path_count[OFS_W-1:0] : '0;
      res.path_is_default = !has_path;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_load) begin
      phase       <= PH_PREFIX;
      position    <= '0;
      host_begin  <= '0;
      host_count  <= '0;
      bracketed   <= 1'b0;
      port_begin  <= '0;
      port_digits <= '0;
      port_value  <= '0;
      path_begin  <= '0;
      failed      <= 1'b0;
    end else if (take) begin
      phase       <= phase_next;
      position    <= position_next;
      host_begin  <= host_begin_next;
      host_count  <= host_count_next;
      bracketed   <= bracketed_next;
      port_begin  <= port_begin_next;
      port_digits <= port_digits_next;
      port_value  <= port_value_next;
      path_begin  <= path_begin_next;
      failed      <= failed_next;
    end
  end

endmodule

@@ hw/rtl/hus_out_reg.sv @@
// ----------------------------------------------------------------------------
// hus_out_reg: verdict register
// Holds one verdict until the downstream side takes it.
// ----------------------------------------------------------------------------
module hus_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_load,
  input  hus_pkg::hus_res_t res,
  input  logic              out_stall,
  output logic              room,
  output logic              out_valid,
  output hus_pkg::hus_res_t res_q
);
  import hus_pkg::*;

  assign room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res_q <= res;
  end

endmodule

@@ hw/rtl/https_url_splitter_unit.sv @@
// ----------------------------------------------------------------------------
// https_url_splitter_unit: https URL authority splitter
// Parses a byte stream URL and reports host, port and path spans.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | beat payload
//  --------+-----------+----------------------+-------------------------------
//  in      | sink      | in_valid / in_stall  | char_byte, last_byte
//  out     | source    | out_valid / out_stall| valid_res .. path_is_default
//
//  One byte is taken per cycle, set by the single parser stage between the
//  two registers, unless a last byte meets a full verdict register; parse
//  state updates, and out_valid rises on a last byte, as a byte is taken.
//  rst is synchronous: clears both beat valids and the parse state.
//  out_stall only holds the flow back when a last byte meets a full verdict
//  register; ordinary bytes keep flowing under a stalled verdict.
// ----------------------------------------------------------------------------
module https_url_splitter_unit #(
  parameter int unsigned MAX_URL_LEN = hus_pkg::MAX_URL_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       char_byte,
  input  logic                             last_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             valid_res,
  output logic [hus_pkg::OFS_W-1:0]        host_start,
  output logic [hus_pkg::OFS_W-1:0]        host_len,
  output logic                             ipv6_host,
  output logic [hus_pkg::OFS_W-1:0]        port_start,
  output logic [hus_pkg::PLEN_W-1:0]       port_len,
  output logic                             port_is_default,
  output logic [hus_pkg::OFS_W-1:0]        path_start,
  output logic [hus_pkg::OFS_W-1:0]        path_len,
  output logic                             path_is_default
);
  import hus_pkg::*;

  hus_beat_t beat;
  logic      beat_valid;
  logic      take;
  logic      room;
  logic      res_load;
  hus_res_t  res;
  hus_res_t  res_q;

  // input register: byte waiting for the parser
  hus_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_byte  (char_byte),
    .last_byte  (last_byte),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // parse state and verdict logic
  hus_parser #(
    .MAX_URL_LEN (MAX_URL_LEN)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .beat_valid (beat_valid),
    .beat       (beat),
    .room       (room),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  // verdict register
  hus_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_load  (res_load),
    .res       (res),
    .out_stall (out_stall),
    .room      (room),
    .out_valid (out_valid),
    .res_q     (res_q)
  );

  assign valid_res       = res_q.valid_res;
  assign host_start      = res_q.host_start;
  assign host_len        = res_q.host_len;
  assign ipv6_host       = res_q.ipv6_host;
  assign port_start      = res_q.port_start;
  assign port_len        = res_q.port_len;
  assign port_is_default = res_q.port_is_default;
  assign path_start      = res_q.path_start;
  assign path_len        = res_q.path_len;
  assign path_is_default = res_q.path_is_default;

endmodule

@@ hw/rtl/hus_checker.sv @@
// ----------------------------------------------------------------------------
// hus_checker: port-level checks for the URL splitter
// Verdict consistency and output beat holding, bound to the top level.
// ----------------------------------------------------------------------------
module hus_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic        valid_res,
  input logic [11:0] host_start,
  input logic [11:0] host_len,
  input logic        ipv6_host,
  input logic [11:0] port_start,
  input logic [2:0]  port_len,
  input logic        port_is_default,
  input logic [11:0] path_start,
  input logic [11:0] path_len,
  input logic        path_is_default
);

  // a stalled verdict stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(valid_res) &&
      $stable(host_start) && $stable(host_len) && $stable(port_start) &&
      $stable(path_start) && $stable(path_len))
    else $error("stalled verdict changed");

  // a rejected URL carries an all-zero verdict
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !valid_res |-> host_start == 12'd0 && host_len == 12'd0 &&
      !ipv6_host && port_start == 12'd0 && port_len == 3'd0 &&
      !port_is_default && path_start == 12'd0 && path_len == 12'd0 &&
      !path_is_default)
    else $error("rejected verdict not cleared");

  // accepted URL: default port exactly when no digits, at most five digits
  a_port: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> (port_is_default == (port_len == 3'd0)) &&
      port_len <= 3'd5 && (!port_is_default || port_start == 12'd0))
    else $error("port fields inconsistent");

  // accepted URL: non-empty host, default path has no span
  a_host_path: assert property (@(posedge clk) disable iff (rst)
    out_valid && valid_res |-> host_len != 12'd0 &&
      (!path_is_default || (path_start == 12'd0 && path_len == 12'd0)))
    else $error("host or path fields inconsistent");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("verdict valid after reset");

endmodule

bind https_url_splitter_unit hus_checker u_hus_checker (.*);
